// ----- hw/rtl/xyzz_pkg.sv -----
package xyzz_pkg;

    localparam int COORD_BITS = 256;
    localparam int WORD_BITS  = 64;
    localparam int CNT_BITS   = $clog2(COORD_BITS);

    // p = 2^256 - 189
    localparam logic [COORD_BITS-1:0] PRIME = {{(COORD_BITS-32){1'b1}}, 32'hFFFFFF43};

    localparam logic [1:0] OP_LOAD = 2'd0;
    localparam logic [1:0] OP_ADD  = 2'd1;
    localparam logic [1:0] OP_DBL  = 2'd2;

    typedef enum logic [1:0] {
        ALU_MUL,
        ALU_ADD,
        ALU_SUB
    } alu_op_t;

    typedef struct packed {
        logic    go;
        alu_op_t op;
    } alu_req_t;

    // Operand sources: 0..15 scratch slot, 16..23 loaded coordinate, 24 curve a
    typedef logic [4:0] src_t;
    localparam src_t SRC_PX    = 5'd16;
    localparam src_t SRC_PY    = 5'd17;
    localparam src_t SRC_PZZ   = 5'd18;
    localparam src_t SRC_PZZZ  = 5'd19;
    localparam src_t SRC_QX    = 5'd20;
    localparam src_t SRC_QY    = 5'd21;
    localparam src_t SRC_QZZ   = 5'd22;
    localparam src_t SRC_QZZZ  = 5'd23;
    localparam src_t SRC_CURVE = 5'd24;

    typedef struct packed {
        alu_op_t    op;
        logic [3:0] dst;
        src_t       src_a;
        src_t       src_b;
        logic       last;
    } uop_t;

    localparam logic [5:0] PC_ADD = 6'd0;
    localparam logic [5:0] PC_DBL = 6'd21;

    function automatic uop_t uop_rom(input logic [5:0] pc);
        uop_t u;
        u = '{ALU_MUL, 4'd0, 5'd0, 5'd0, 1'b0};
        case (pc)
            // add-2008-s
            6'd0:  u = '{ALU_MUL, 4'd4,  SRC_PX,   SRC_QZZ,  1'b0}; // u1
            6'd1:  u = '{ALU_MUL, 4'd5,  SRC_QX,   SRC_PZZ,  1'b0}; // u2
            6'd2:  u = '{ALU_MUL, 4'd6,  SRC_PY,   SRC_QZZZ, 1'b0}; // s1
            6'd3:  u = '{ALU_MUL, 4'd7,  SRC_QY,   SRC_PZZZ, 1'b0}; // s2
            6'd4:  u = '{ALU_SUB, 4'd5,  5'd5,     5'd4,     1'b0}; // p
            6'd5:  u = '{ALU_SUB, 4'd7,  5'd7,     5'd6,     1'b0}; // r
            6'd6:  u = '{ALU_MUL, 4'd8,  5'd5,     5'd5,     1'b0}; // pp
            6'd7:  u = '{ALU_MUL, 4'd9,  5'd8,     5'd5,     1'b0}; // ppp
            6'd8:  u = '{ALU_MUL, 4'd4,  5'd4,     5'd8,     1'b0}; // q
            6'd9:  u = '{ALU_MUL, 4'd10, 5'd7,     5'd7,     1'b0}; // rr
            6'd10: u = '{ALU_SUB, 4'd10, 5'd10,    5'd9,     1'b0};
            6'd11: u = '{ALU_ADD, 4'd11, 5'd4,     5'd4,     1'b0};
            6'd12: u = '{ALU_SUB, 4'd0,  5'd10,    5'd11,    1'b0}; // x3
            6'd13: u = '{ALU_SUB, 4'd11, 5'd4,     5'd0,     1'b0};
            6'd14: u = '{ALU_MUL, 4'd11, 5'd7,     5'd11,    1'b0};
            6'd15: u = '{ALU_MUL, 4'd12, 5'd6,     5'd9,     1'b0};
            6'd16: u = '{ALU_SUB, 4'd1,  5'd11,    5'd12,    1'b0}; // y3
            6'd17: u = '{ALU_MUL, 4'd12, SRC_PZZ,  SRC_QZZ,  1'b0};
            6'd18: u = '{ALU_MUL, 4'd2,  5'd12,    5'd8,     1'b0}; // zz3
            6'd19: u = '{ALU_MUL, 4'd13, SRC_PZZZ, SRC_QZZZ, 1'b0};
            6'd20: u = '{ALU_MUL, 4'd3,  5'd13,    5'd9,     1'b1}; // zzz3
            // dbl-2008-s-1
            6'd21: u = '{ALU_ADD, 4'd4,  SRC_PY,   SRC_PY,   1'b0}; // u
            6'd22: u = '{ALU_MUL, 4'd5,  5'd4,     5'd4,     1'b0}; // v
            6'd23: u = '{ALU_MUL, 4'd6,  5'd4,     5'd5,     1'b0}; // w
            6'd24: u = '{ALU_MUL, 4'd7,  SRC_PX,   5'd5,     1'b0}; // s
            6'd25: u = '{ALU_MUL, 4'd8,  SRC_PX,   SRC_PX,   1'b0}; // xx
            6'd26: u = '{ALU_ADD, 4'd9,  5'd8,     5'd8,     1'b0};
            6'd27: u = '{ALU_ADD, 4'd9,  5'd9,     5'd8,     1'b0};
            6'd28: u = '{ALU_MUL, 4'd10, SRC_PZZ,  SRC_PZZ,  1'b0};
            6'd29: u = '{ALU_MUL, 4'd10, SRC_CURVE, 5'd10,   1'b0};
            6'd30: u = '{ALU_ADD, 4'd9,  5'd9,     5'd10,    1'b0}; // m
            6'd31: u = '{ALU_MUL, 4'd11, 5'd9,     5'd9,     1'b0};
            6'd32: u = '{ALU_ADD, 4'd12, 5'd7,     5'd7,     1'b0};
            6'd33: u = '{ALU_SUB, 4'd0,  5'd11,    5'd12,    1'b0}; // x3
            6'd34: u = '{ALU_SUB, 4'd12, 5'd7,     5'd0,     1'b0};
            6'd35: u = '{ALU_MUL, 4'd12, 5'd9,     5'd12,    1'b0};
            6'd36: u = '{ALU_MUL, 4'd13, 5'd6,     SRC_PY,   1'b0};
            6'd37: u = '{ALU_SUB, 4'd1,  5'd12,    5'd13,    1'b0}; // y3
            6'd38: u = '{ALU_MUL, 4'd2,  5'd5,     SRC_PZZ,  1'b0}; // zz3
            6'd39: u = '{ALU_MUL, 4'd3,  5'd6,     SRC_PZZZ, 1'b1}; // zzz3
            default: u = '{ALU_MUL, 4'd0, 5'd0, 5'd0, 1'b1};
        endcase
        return u;
    endfunction

endpackage

// ----- hw/rtl/xyzz_ram.sv -----
module xyzz_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- hw/rtl/xyzz_arith.sv -----
module xyzz_arith (
    input  logic                                clk,
    input  logic                                rst_n,
    input  xyzz_pkg::alu_req_t                  req,
    input  logic [xyzz_pkg::COORD_BITS-1:0]     a,
    input  logic [xyzz_pkg::COORD_BITS-1:0]     b,
    output logic                                done,
    output logic [xyzz_pkg::COORD_BITS-1:0]     res
);
    import xyzz_pkg::*;

    typedef enum logic [1:0] {
        A_IDLE,
        A_MUL,
        A_ADD,
        A_RED
    } astate_t;

    astate_t               state_reg, state_next;
    logic [CNT_BITS-1:0]   cnt_reg, cnt_next;
    logic                  rcnt_reg, rcnt_next;
    logic                  done_reg, done_next;

    logic [COORD_BITS+1:0] acc_reg, acc_next;
    logic [COORD_BITS-1:0] areg_reg, areg_next;
    logic [COORD_BITS-1:0] breg_reg, breg_next;

    logic                  q;
    logic [COORD_BITS+2:0] mul_sum;
    logic [COORD_BITS+2:0] red_diff;

    // radix-2 Montgomery step: t = (t + a_i*b + q*p) / 2
    assign q        = acc_reg[0] ^ (areg_reg[0] & breg_reg[0]);
    assign mul_sum  = {1'b0, acc_reg}
                    + (areg_reg[0] ? {3'b0, breg_reg} : '0)
                    + (q ? {3'b0, PRIME} : '0);
    assign red_diff = {1'b0, acc_reg} - {3'b0, PRIME};

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        rcnt_next  = rcnt_reg;
        done_next  = 1'b0;
        acc_next   = acc_reg;
        areg_next  = areg_reg;
        breg_next  = breg_reg;
        unique case (state_reg)
            A_IDLE:
            begin
                if (req.go)
                begin
                    unique case (req.op)
                        ALU_MUL:
                        begin
                            acc_next   = '0;
                            areg_next  = a;
                            breg_next  = b;
                            cnt_next   = '0;
                            state_next = A_MUL;
                        end
                        ALU_ADD:
                        begin
                            acc_next   = {2'b0, a};
                            breg_next  = b;
                            state_next = A_ADD;
                        end
                        ALU_SUB:
                        begin
                            // subtrahend is reduced, so p - b stays non-negative
                            acc_next   = {2'b0, PRIME} - {2'b0, b};
                            breg_next  = a;
                            state_next = A_ADD;
                        end
                        default:
                        begin
                            state_next = A_IDLE;
                        end
                    endcase
                end
            end
            A_MUL:
            begin
                acc_next  = mul_sum[COORD_BITS+2:1];
                areg_next = {1'b0, areg_reg[COORD_BITS-1:1]};
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == CNT_BITS'(COORD_BITS - 1))
                begin
                    rcnt_next  = 1'b0;
                    state_next = A_RED;
                end
            end
            A_ADD:
            begin
                acc_next   = acc_reg + {2'b0, breg_reg};
                rcnt_next  = 1'b0;
                state_next = A_RED;
            end
            A_RED:
            begin
                // value is below 3p: two conditional subtractions
                if (!red_diff[COORD_BITS+2])
                begin
                    acc_next = red_diff[COORD_BITS+1:0];
                end
                rcnt_next = 1'b1;
                if (rcnt_reg)
                begin
                    done_next  = 1'b1;
                    state_next = A_IDLE;
                end
            end
            default:
            begin
                state_next = A_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= A_IDLE;
            cnt_reg   <= '0;
            rcnt_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            rcnt_reg  <= rcnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        areg_reg <= areg_next;
        breg_reg <= breg_next;
    end

    assign done = done_reg;
    assign res  = acc_reg[COORD_BITS-1:0];

endmodule

// ----- hw/rtl/ecc_xyzz_point_unit.sv -----
// XYZZ point add / double unit over p = 2^256 - 189, Montgomery form (R = 2^256).
//
// Command channel: an item is taken when start is high and busy is low.
//   opcode load writes word_value to operand slot word_index; busy
//   stays low. opcode add (P+Q) or double (2P) raises busy for the whole run.
// Configuration: cfg_we writes cfg_data to curve_a word cfg_index at once.
//   Write it only while busy is low.
// Results: sixteen beats on result_valid, x word 0 first, zzz word 3 last with
//   last set. Beats come every cycle within a coordinate, with a pause between
//   coordinates while the next one is read from scratch. The receiver cannot stall; busy falls with the last beat.
// Sequencing: a run is a sequence of 21 (add) or 19 (double) field operations
//   held in a micro-op table, each reading its operands from scratch, the
//   operand RAM or the curve a register and writing its result back to scratch.
//   The bit-serial Montgomery multiplier takes one bit of its first operand
//   per step and ends each product with two conditional subtractions.
// Reset: curve a returns to 945 (5 in Montgomery form); operand and scratch
//   RAMs are not cleared, so every operand word must be loaded before a run.
module ecc_xyzz_point_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  opcode,
    input  logic [4:0]  word_index,
    input  logic [63:0] word_value,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data,
    output logic        result_valid,
    output logic [3:0]  result_index,
    output logic [63:0] result_value,
    output logic        last
);
    import xyzz_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH,
        S_EXEC,
        S_WAIT,
        S_OUT_RD,
        S_OUT_CAP,
        S_OUT_EMIT
    } state_t;

    state_t                state_reg, state_next;
    logic [5:0]            pc_reg, pc_next;
    logic [2:0]            fcnt_reg, fcnt_next;
    logic                  opsel_reg, opsel_next;
    logic [1:0]            ocoord_reg, ocoord_next;
    logic [1:0]            oword_reg, oword_next;
    logic                  result_valid_reg, result_valid_next;
    logic                  last_reg, last_next;
    logic [3:0]            result_index_reg, result_index_next;
    logic [WORD_BITS-1:0]  result_value_reg, result_value_next;

    logic [COORD_BITS-1:0] opa_reg, opa_next;
    logic [COORD_BITS-1:0] opb_reg, opb_next;
    logic [COORD_BITS-1:0] obuf_reg, obuf_next;
    logic [COORD_BITS-1:0] curve_a_reg;

    uop_t                  uop;
    src_t                  src;
    logic [1:0]            wsel;
    logic [COORD_BITS-1:0] opnd_new;
    logic                  fetch_done;
    logic                  cmd_accept;

    logic                  opr_we;
    logic [4:0]            opr_raddr;
    logic [WORD_BITS-1:0]  opr_rdata;
    logic                  scr_we;
    logic [3:0]            scr_raddr;
    logic [COORD_BITS-1:0] scr_rdata;

    alu_req_t              alu_req;
    logic                  alu_done;
    logic [COORD_BITS-1:0] alu_res;

    assign busy       = (state_reg != S_IDLE);
    assign cmd_accept = start && !busy;
    assign uop        = uop_rom(pc_reg);
    assign src        = opsel_reg ? uop.src_b : uop.src_a;
    assign wsel       = fcnt_reg[1:0] - 2'd1;

    assign opr_we    = cmd_accept && (opcode == OP_LOAD);
    assign opr_raddr = {src[2:0], fcnt_reg[1:0]};

    assign scr_we    = (state_reg == S_WAIT) && alu_done;
    assign scr_raddr = (state_reg == S_FETCH) ? src[3:0] : {2'b0, ocoord_reg};

    assign alu_req.go = (state_reg == S_EXEC);
    assign alu_req.op = uop.op;

    xyzz_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (32)
    ) u_operand_ram (
        .clk   (clk),
        .we    (opr_we),
        .waddr (word_index),
        .wdata (word_value),
        .raddr (opr_raddr),
        .rdata (opr_rdata)
    );

    xyzz_ram #(
        .WIDTH (COORD_BITS),
        .DEPTH (16)
    ) u_scratch_ram (
        .clk   (clk),
        .we    (scr_we),
        .waddr (uop.dst),
        .wdata (alu_res),
        .raddr (scr_raddr),
        .rdata (scr_rdata)
    );

    xyzz_arith u_arith (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (alu_req),
        .a     (opa_reg),
        .b     (opb_reg),
        .done  (alu_done),
        .res   (alu_res)
    );

    // Operand gather: scratch is one read, a loaded coordinate four word reads,
    // curve a is taken straight from its register.
    always_comb
    begin
        opnd_new   = opsel_reg ? opb_reg : opa_reg;
        fetch_done = 1'b0;
        if (!src[4])
        begin
            if (fcnt_reg == 3'd1)
            begin
                opnd_new   = scr_rdata;
                fetch_done = 1'b1;
            end
        end
        else if (src[3])
        begin
            opnd_new   = curve_a_reg;
            fetch_done = 1'b1;
        end
        else
        begin
            if (fcnt_reg != 3'd0)
            begin
                opnd_new[wsel*WORD_BITS +: WORD_BITS] = opr_rdata;
            end
            fetch_done = (fcnt_reg == 3'd4);
        end
    end

    always_comb
    begin
        state_next        = state_reg;
        pc_next           = pc_reg;
        fcnt_next         = fcnt_reg;
        opsel_next        = opsel_reg;
        ocoord_next       = ocoord_reg;
        oword_next        = oword_reg;
        result_valid_next = 1'b0;
        last_next         = 1'b0;
        result_index_next = result_index_reg;
        result_value_next = result_value_reg;
        opa_next          = opa_reg;
        opb_next          = opb_reg;
        obuf_next         = obuf_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_accept && (opcode == OP_ADD || opcode == OP_DBL))
                begin
                    pc_next    = (opcode == OP_ADD) ? PC_ADD : PC_DBL;
                    fcnt_next  = 3'd0;
                    opsel_next = 1'b0;
                    state_next = S_FETCH;
                end
            end
            S_FETCH:
            begin
                if (opsel_reg)
                begin
                    opb_next = opnd_new;
                end
                else
                begin
                    opa_next = opnd_new;
                end
                fcnt_next = fcnt_reg + 3'd1;
                if (fetch_done)
                begin
                    fcnt_next  = 3'd0;
                    opsel_next = !opsel_reg;
                    if (opsel_reg)
                    begin
                        state_next = S_EXEC;
                    end
                end
            end
            S_EXEC:
            begin
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                if (alu_done)
                begin
                    if (uop.last)
                    begin
                        ocoord_next = 2'd0;
                        oword_next  = 2'd0;
                        state_next  = S_OUT_RD;
                    end
                    else
                    begin
                        pc_next    = pc_reg + 6'd1;
                        state_next = S_FETCH;
                    end
                end
            end
            S_OUT_RD:
            begin
                state_next = S_OUT_CAP;
            end
            S_OUT_CAP:
            begin
                obuf_next  = scr_rdata;
                state_next = S_OUT_EMIT;
            end
            S_OUT_EMIT:
            begin
                result_valid_next = 1'b1;
                result_index_next = {ocoord_reg, oword_reg};
                result_value_next = obuf_reg[oword_reg*WORD_BITS +: WORD_BITS];
                last_next         = (ocoord_reg == 2'd3) && (oword_reg == 2'd3);
                oword_next        = oword_reg + 2'd1;
                if (oword_reg == 2'd3)
                begin
                    if (ocoord_reg == 2'd3)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        ocoord_next = ocoord_reg + 2'd1;
                        state_next  = S_OUT_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            pc_reg           <= '0;
            fcnt_reg         <= '0;
            opsel_reg        <= 1'b0;
            ocoord_reg       <= '0;
            oword_reg        <= '0;
            result_valid_reg <= 1'b0;
            last_reg         <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            pc_reg           <= pc_next;
            fcnt_reg         <= fcnt_next;
            opsel_reg        <= opsel_next;
            ocoord_reg       <= ocoord_next;
            oword_reg        <= oword_next;
            result_valid_reg <= result_valid_next;
            last_reg         <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_index_reg <= result_index_next;
        result_value_reg <= result_value_next;
        opa_reg          <= opa_next;
        opb_reg          <= opb_next;
        obuf_reg         <= obuf_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            curve_a_reg <= COORD_BITS'(945);
        end
        else if (cfg_we)
        begin
            curve_a_reg[cfg_index*WORD_BITS +: WORD_BITS] <= cfg_data;
        end
    end

    assign result_valid = result_valid_reg;
    assign result_index = result_index_reg;
    assign result_value = result_value_reg;
    assign last         = last_reg;

    // A product or sum only completes while the sequencer waits for it
    assert property (@(posedge clk) disable iff (!rst_n)
        alu_done |-> (state_reg == S_WAIT))
        else $error("arith done outside wait state");

    // A run command must leave idle on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_accept && (opcode == OP_ADD || opcode == OP_DBL)) |=> busy)
        else $error("run command not started");

    // The final beat carries the top word index and ends the run
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && last) |-> (result_index == 4'd15 && !busy))
        else $error("last beat misplaced");

    // Beats are produced only during a run's output phase
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(state_reg == S_OUT_EMIT))
        else $error("stray result beat");

endmodule
